// ===== design/line_editor_tokenizer_unit_defines.svh =====
// Assertion helpers for the line editor tokenizer unit.
// Each macro expects clk and rst_n in scope.
`ifndef LINE_EDITOR_TOKENIZER_UNIT_DEFINES_SVH
`define LINE_EDITOR_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LETOK_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("letok check failed: same-cycle implication");
`define LETOK_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("letok check failed: next-cycle implication");
`else
`define LETOK_ASSERT_NOW(name, ante, cons)
`define LETOK_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== design/letok_pkg.sv =====
package letok_pkg;

    // Default sizes
    localparam int LINE_DEPTH_DEF = 32;
    localparam int MAX_TOKENS_DEF = 4;

    // Character codes
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

    // Result kinds
    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_TOKEN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [1:0] tok;
        logic       tend;
        logic       drop;
        logic       last;
    } item_t;

    // Lower A-Z, pass everything else
    function automatic logic [7:0] lower_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + CASE_SHIFT;
        end
        return r;
    endfunction

endpackage

// ===== design/letok_store.sv =====
module letok_store import letok_pkg::*; #(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // Write one byte of the line
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/line_editor_tokenizer_unit.sv =====
// Line editor with space tokenizer. Every received byte on the slave stream is
// echoed first (tuser 0). Ordinary bytes are appended to a line store of
// LINE_DEPTH bytes (extra bytes are dropped), backspace removes the last byte,
// and CR or LF on a non-empty line walks the stored line and emits each
// space-separated token, A-Z lowered, as tuser 1 items with the token number
// and an end mark; tokens past MAX_TOKENS are dropped and flagged on the final
// item, which also carries tlast. A stored NUL ends the line early. An
// ordinary byte or backspace is taken in ST_IDLE and the block is ready again
// once ST_FLUSH has sent its echo item. An end of line walks the stored line,
// reading one byte per cycle from the single read port of the line store; a
// stalled master stream holds the walk. An input item is accepted while the
// previous result still waits in the output register.
`include "line_editor_tokenizer_unit_defines.svh"

module line_editor_tokenizer_unit import letok_pkg::*; #(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF,
    parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_char, [9:8] token_number,
                                        // [10] token_end, [11] tokens_dropped
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast
);

    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int TW = $clog2(MAX_TOKENS + 1);

    state_t        state_reg, state_next;
    logic [LW-1:0] line_len_reg, line_len_next;
    logic [LW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          data_valid_reg, data_valid_next;
    logic          data_last_reg, data_last_next;
    logic [TW-1:0] ntok_reg, ntok_next;
    logic [TW-1:0] cur_tok_reg, cur_tok_next;
    logic          in_tok_reg, in_tok_next;
    logic          skip_reg, skip_next;
    logic          dropped_reg, dropped_next;
    item_t         pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;
    item_t         out_item_reg, out_item_next;

    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [LW-1:0] rd_ptr_inc;
    logic          out_free;
    logic          is_nul;
    logic          is_space;
    logic          new_tok;
    logic          tok_ok;
    logic          emit;
    logic          consume;
    logic [TW-1:0] emit_tok;
    logic [TW+1:0] emit_tok_ext;

    letok_store #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (line_len_reg[AW-1:0]),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Decode the byte coming out of the store
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign rd_ptr_inc   = rd_ptr_reg + LW'(1);
    assign is_nul       = (rd_data == CH_NUL);
    assign is_space     = (rd_data == CH_SPACE);
    assign new_tok      = !in_tok_reg;
    assign tok_ok       = (ntok_reg < TW'(MAX_TOKENS));
    assign emit         = data_valid_reg && !is_nul && !is_space
                          && (new_tok ? tok_ok : !skip_reg);
    assign consume      = data_valid_reg && (!emit || out_free);
    assign emit_tok     = new_tok ? ntok_reg : cur_tok_reg;
    assign emit_tok_ext = {2'b00, emit_tok};

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        line_len_next   = line_len_reg;
        rd_ptr_next     = rd_ptr_reg;
        data_valid_next = data_valid_reg;
        data_last_next  = data_last_reg;
        ntok_next       = ntok_reg;
        cur_tok_next    = cur_tok_reg;
        in_tok_next     = in_tok_reg;
        skip_next       = skip_reg;
        dropped_next    = dropped_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_item_next   = out_item_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    pend_next    = '{kind: KIND_ECHO, ch: s_axis_tdata, tok: 2'd0,
                                     tend: 1'b0, drop: 1'b0, last: 1'b0};
                    dropped_next = 1'b0;
                    state_next   = ST_FLUSH;
                    if (s_axis_tdata == CH_BS)
                    begin
                        if (line_len_reg != '0)
                        begin
                            line_len_next = line_len_reg - LW'(1);
                        end
                    end
                    else if (s_axis_tdata == CH_CR || s_axis_tdata == CH_LF)
                    begin
                        if (line_len_reg != '0)
                        begin
                            state_next      = ST_WALK;
                            rd_ptr_next     = '0;
                            data_valid_next = 1'b0;
                            ntok_next       = '0;
                            in_tok_next     = 1'b0;
                            skip_next       = 1'b0;
                        end
                    end
                    else if (line_len_reg < LW'(LINE_DEPTH))
                    begin
                        wr_en         = 1'b1;
                        line_len_next = line_len_reg + LW'(1);
                    end
                end
            end

            ST_WALK:
            begin
                // Issue the next read when the data stage is free or draining
                if (rd_ptr_reg < line_len_reg && (!data_valid_reg || consume))
                begin
                    rd_en           = 1'b1;
                    rd_ptr_next     = rd_ptr_inc;
                    data_last_next  = (rd_ptr_inc == line_len_reg);
                    data_valid_next = 1'b1;
                end
                else if (consume)
                begin
                    data_valid_next = 1'b0;
                end

                // Process the byte in the data stage
                if (consume)
                begin
                    if (is_nul)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        if (is_space)
                        begin
                            in_tok_next = 1'b0;
                            if (pend_reg.kind == KIND_TOKEN)
                            begin
                                pend_next.tend = 1'b1;
                            end
                        end
                        else if (new_tok)
                        begin
                            in_tok_next = 1'b1;
                            if (tok_ok)
                            begin
                                ntok_next    = ntok_reg + TW'(1);
                                cur_tok_next = ntok_reg;
                                skip_next    = 1'b0;
                            end
                            else
                            begin
                                skip_next    = 1'b1;
                                dropped_next = 1'b1;
                            end
                        end

                        // Push the held item out and hold the new character
                        if (emit)
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = pend_reg;
                            pend_next      = '{kind: KIND_TOKEN,
                                               ch: lower_char(rd_data),
                                               tok: emit_tok_ext[1:0],
                                               tend: 1'b0, drop: 1'b0, last: 1'b0};
                        end
                        if (data_last_reg)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end

                // Leave the walk with an empty line
                if (state_next == ST_FLUSH)
                begin
                    data_valid_next = 1'b0;
                    line_len_next   = '0;
                end
            end

            ST_FLUSH:
            begin
                // Send the final item of this input
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_item_next      = pend_reg;
                    out_item_next.tend = pend_reg.kind;
                    out_item_next.drop = dropped_reg;
                    out_item_next.last = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_len_reg   <= '0;
            rd_ptr_reg     <= '0;
            data_valid_reg <= 1'b0;
            data_last_reg  <= 1'b0;
            ntok_reg       <= '0;
            cur_tok_reg    <= '0;
            in_tok_reg     <= 1'b0;
            skip_reg       <= 1'b0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_len_reg   <= line_len_next;
            rd_ptr_reg     <= rd_ptr_next;
            data_valid_reg <= data_valid_next;
            data_last_reg  <= data_last_next;
            ntok_reg       <= ntok_next;
            cur_tok_reg    <= cur_tok_next;
            in_tok_reg     <= in_tok_next;
            skip_reg       <= skip_next;
            dropped_reg    <= dropped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_item_reg <= out_item_next;
    end

    // Drive the streams
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_item_reg.drop, out_item_reg.tend,
                            out_item_reg.tok, out_item_reg.ch};
    assign m_axis_tuser  = out_item_reg.kind;
    assign m_axis_tlast  = out_item_reg.last;

    // Checks
    `LETOK_ASSERT_NOW(a_data_only_in_walk, data_valid_reg, state_reg == ST_WALK)
    `LETOK_ASSERT_NOW(a_len_in_range, 1'b1, line_len_reg <= LW'(LINE_DEPTH))
    `LETOK_ASSERT_NOW(a_tok_in_range, 1'b1, ntok_reg <= TW'(MAX_TOKENS))
    `LETOK_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
                       state_reg != ST_IDLE)

endmodule
